>>> rtl/alucs_pkg.sv
// Shared types, codes and constants for the ALU with carry latch and skip condition.
package alucs_pkg;

   localparam int unsigned DATA_WIDTH = 16;

   localparam logic [DATA_WIDTH-1:0] FLAGS_RESET      = 16'h0008;
   localparam logic [DATA_WIDTH-1:0] CARRY_CLEAR_MASK = 16'hfffd;
   localparam logic [DATA_WIDTH-1:0] MERGE_LOW_MASK   = 16'h01ff;
   localparam int unsigned           MERGE_SHIFT      = 9;

   // ALU functions
   localparam logic [2:0] CMD_ADD   = 3'd0;
   localparam logic [2:0] CMD_SUB   = 3'd1;
   localparam logic [2:0] CMD_AND   = 3'd2;
   localparam logic [2:0] CMD_OR    = 3'd3;
   localparam logic [2:0] CMD_SHL   = 3'd4;
   localparam logic [2:0] CMD_SHR   = 3'd5;
   localparam logic [2:0] CMD_MERGE = 3'd6;
   localparam logic [2:0] CMD_ZERO  = 3'd7;

   // skip conditions
   localparam logic [2:0] COND_EQ    = 3'd0;
   localparam logic [2:0] COND_NEQ   = 3'd1;
   localparam logic [2:0] COND_SLT   = 3'd2;
   localparam logic [2:0] COND_SLTEQ = 3'd3;
   localparam logic [2:0] COND_SGT   = 3'd4;
   localparam logic [2:0] COND_SGTEQ = 3'd5;
   localparam logic [2:0] COND_LT    = 3'd6;
   localparam logic [2:0] COND_LTEQ  = 3'd7;

   localparam int unsigned CARRY_BIT = 1;

   typedef struct packed {
      logic [15:0] operand_a;
      logic [15:0] operand_b;
      logic [2:0]  command;
      logic [2:0]  condition;
      logic        check_condition;
      logic        update_carry;
      logic        load_flags;
   } req_payload_type;

   typedef struct packed {
      logic [15:0] alu_result;
      logic        skip;
      logic [15:0] flags_value;
   } rsp_payload_type;

   // carry information from the ALU to the flags unit
   typedef struct packed {
      logic carry_load;
      logic carry_out;
   } alu_status_type;

endpackage

>>> rtl/alucs_stream_if.sv
// Valid/ready stream interface carrying one payload of a given type.
interface alucs_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

>>> rtl/alucs_alu.sv
// ALU function unit: result and carry of one request.
module alucs_alu (
   input  logic [15:0]            operand_a,
   input  logic [15:0]            operand_b,
   input  logic [2:0]             command,
   output logic [15:0]            alu_result,
   output alucs_pkg::alu_status_type status
);

   logic [16:0] sum_full;
   logic [16:0] diff_full;
   logic [4:0]  shift_amount;
   logic        shift_overflow;

   assign sum_full       = {1'b0, operand_a} + {1'b0, operand_b};
   assign diff_full      = {1'b0, operand_a} - {1'b0, operand_b};
   assign shift_amount   = {1'b0, operand_b[3:0]} + 5'd1;
   // b + 1 reaching 16 or more clears the result
   assign shift_overflow = (operand_b > 16'd14);

   always_comb begin
      status.carry_load = 1'b0;
      status.carry_out  = 1'b0;
      case (command)
         alucs_pkg::CMD_ADD: begin
            alu_result        = sum_full[15:0];
            status.carry_load = 1'b1;
            status.carry_out  = sum_full[16];
         end
         alucs_pkg::CMD_SUB: begin
            alu_result        = diff_full[15:0];
            status.carry_load = 1'b1;
            status.carry_out  = diff_full[16];
         end
         alucs_pkg::CMD_AND: alu_result = operand_a & operand_b;
         alucs_pkg::CMD_OR:  alu_result = operand_a | operand_b;
         alucs_pkg::CMD_SHL: alu_result = shift_overflow ? 16'd0 : (operand_a << shift_amount);
         alucs_pkg::CMD_SHR: alu_result = shift_overflow ? 16'd0 : (operand_a >> shift_amount);
         alucs_pkg::CMD_MERGE: begin
            alu_result = (operand_a << alucs_pkg::MERGE_SHIFT)
                       | (operand_b & alucs_pkg::MERGE_LOW_MASK);
         end
         default: alu_result = 16'd0;
      endcase
   end

endmodule

>>> rtl/alucs_flags.sv
// Flags register, pending carry latch and skip condition evaluation.
module alucs_flags (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     execute,
   input  logic [15:0]              alu_result,
   input  alucs_pkg::alu_status_type status,
   input  logic [2:0]               condition,
   input  logic                     check_condition,
   input  logic                     update_carry,
   input  logic                     load_flags,
   output logic                     skip,
   output logic [15:0]              flags_next
);

   logic [15:0] flags_ff;
   logic [15:0] flags_in;
   logic        carry_pending_ff;
   logic        carry_pending_in;
   logic        old_carry;
   logic        is_zero;
   logic        is_neg;
   logic        cond_true;

   assign old_carry = flags_ff[alucs_pkg::CARRY_BIT];
   assign is_zero   = (alu_result == 16'd0);
   assign is_neg    = alu_result[15];

   always_comb begin
      case (condition)
         alucs_pkg::COND_EQ:    cond_true = is_zero;
         alucs_pkg::COND_NEQ:   cond_true = !is_zero;
         alucs_pkg::COND_SLT:   cond_true = is_neg;
         alucs_pkg::COND_SLTEQ: cond_true = is_zero || is_neg;
         alucs_pkg::COND_SGT:   cond_true = !is_neg && !is_zero;
         alucs_pkg::COND_SGTEQ: cond_true = !is_neg;
         alucs_pkg::COND_LT:    cond_true = old_carry && !is_zero;
         default:               cond_true = old_carry || is_zero;
      endcase
   end

   assign skip = check_condition && cond_true;

   assign carry_pending_in = status.carry_load ? status.carry_out : carry_pending_ff;

   always_comb begin
      if (load_flags) begin
         flags_in = alu_result;
      end else if (update_carry) begin
         flags_in = (flags_ff & alucs_pkg::CARRY_CLEAR_MASK)
                  | ({15'd0, carry_pending_in} << alucs_pkg::CARRY_BIT);
      end else begin
         flags_in = flags_ff;
      end
   end

   assign flags_next = flags_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff         <= alucs_pkg::FLAGS_RESET;
         carry_pending_ff <= 1'b0;
      end else if (execute) begin
         flags_ff         <= flags_in;
         carry_pending_ff <= carry_pending_in;
      end
   end

`ifndef SYNTHESIS
   a_flags_reset: assert property (@(posedge clock)
      reset |=> flags_ff == alucs_pkg::FLAGS_RESET && !carry_pending_ff)
      else $error("flags not at reset value after reset");

   a_flags_hold: assert property (@(posedge clock) disable iff (reset)
      !execute |=> $stable(flags_ff) && $stable(carry_pending_ff))
      else $error("flags changed without a request");

   a_carry_only: assert property (@(posedge clock) disable iff (reset)
      execute && !load_flags |=>
         (flags_ff & alucs_pkg::CARRY_CLEAR_MASK)
            == ($past(flags_ff) & alucs_pkg::CARRY_CLEAR_MASK))
      else $error("carry update touched bits other than the carry");

   a_pending_keep: assert property (@(posedge clock) disable iff (reset)
      execute && !status.carry_load |=> $stable(carry_pending_ff))
      else $error("pending carry changed on a non-arithmetic function");
`endif

endmodule

>>> rtl/alu_with_carry_and_skip_condition_core.sv
// Top level: ALU with carry latch and skip condition, input and result registers.
//
//   channel     direction  handshake          payload
//   req_stream  in         valid / ready      operand_a, operand_b, command, condition,
//                                             check_condition, update_carry, load_flags
//   rsp_stream  out        valid / ready      alu_result, skip, flags_value
//
// One request per clock while the result is not stalled. A request is captured in the input
// register, evaluated and written with the flags update into the result register.
// The flags register is updated in the same cycle, so the next request sees it.
// Reset (synchronous) sets the flags to 8 and clears the pending carry.
// A stalled result holds both registers; req_stream.ready drops only when both are full.
module alu_with_carry_and_skip_condition_core (
   input  logic clock,
   input  logic reset,
   alucs_stream_if.sink   req_stream,
   alucs_stream_if.source rsp_stream
);

   logic                        in_valid_ff;
   alucs_pkg::req_payload_type  in_payload_ff;
   logic                        out_valid_ff;
   alucs_pkg::rsp_payload_type  out_payload_ff;
   alucs_pkg::rsp_payload_type  out_payload_in;

   logic                        out_free;
   logic                        execute;
   logic                        take_req;
   logic [15:0]                 alu_result;
   alucs_pkg::alu_status_type   status;
   logic                        skip;
   logic [15:0]                 flags_next;

   assign out_free = !out_valid_ff || rsp_stream.ready;
   assign execute  = in_valid_ff && out_free;
   assign take_req = req_stream.valid && req_stream.ready;

   assign req_stream.ready   = !in_valid_ff || out_free;
   assign rsp_stream.valid   = out_valid_ff;
   assign rsp_stream.payload = out_payload_ff;

   alucs_alu u_alu (
      .operand_a  (in_payload_ff.operand_a),
      .operand_b  (in_payload_ff.operand_b),
      .command    (in_payload_ff.command),
      .alu_result (alu_result),
      .status     (status)
   );

   alucs_flags u_flags (
      .clock           (clock),
      .reset           (reset),
      .execute         (execute),
      .alu_result      (alu_result),
      .status          (status),
      .condition       (in_payload_ff.condition),
      .check_condition (in_payload_ff.check_condition),
      .update_carry    (in_payload_ff.update_carry),
      .load_flags      (in_payload_ff.load_flags),
      .skip            (skip),
      .flags_next      (flags_next)
   );

   assign out_payload_in.alu_result  = alu_result;
   assign out_payload_in.skip        = skip;
   assign out_payload_in.flags_value = flags_next;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_stream.ready) begin
            in_valid_ff <= req_stream.valid;
         end
         if (out_free) begin
            out_valid_ff <= in_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take_req) begin
         in_payload_ff <= req_stream.payload;
      end
      if (execute) begin
         out_payload_ff <= out_payload_in;
      end
   end

`ifndef SYNTHESIS
   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !execute |=> in_valid_ff && $stable(in_payload_ff))
      else $error("waiting request lost or changed");

   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_stream.ready |=> out_valid_ff && $stable(out_payload_ff))
      else $error("stalled result lost or changed");

   a_exec_fills: assert property (@(posedge clock) disable iff (reset)
      execute |=> out_valid_ff)
      else $error("evaluated request did not reach the result register");
`endif

endmodule

>>> bench/tb_alu_with_carry_and_skip_condition_core.sv
// Testbench for the ALU core: random and directed requests checked against a flags predictor.
`timescale 1ns / 1ps

module tb_alu_with_carry_and_skip_condition_core;
   import alucs_pkg::*;

   localparam int RANDOM_REQUESTS = 1600;
   localparam int CYCLE_LIMIT     = 400000;
   localparam int DRAIN_CYCLES    = 4;

   // Predicts ALU result, skip and flags, and holds the responses still owed.
   class flags_scoreboard;
      logic [15:0]     flags;
      logic            carry_pending;
      rsp_payload_type owed_q[$];
      int              errors;

      function new();
         flags         = FLAGS_RESET;
         carry_pending = 1'b0;
         errors        = 0;
      endfunction

      function void note_request(req_payload_type p);
         logic [16:0]     full;
         logic [15:0]     r;
         logic            old_carry;
         logic            zero;
         logic            neg;
         logic            holds;
         int unsigned     count;
         rsp_payload_type e;
         old_carry = flags[CARRY_BIT];
         count     = p.operand_b + 1;
         r         = '0;
         case (p.command)
            CMD_ADD: begin
               full          = {1'b0, p.operand_a} + {1'b0, p.operand_b};
               r             = full[15:0];
               carry_pending = full[16];
            end
            CMD_SUB: begin
               full          = {1'b0, p.operand_a} - {1'b0, p.operand_b};
               r             = full[15:0];
               carry_pending = full[16];
            end
            CMD_AND:   r = p.operand_a & p.operand_b;
            CMD_OR:    r = p.operand_a | p.operand_b;
            CMD_SHL:   r = (count >= 16) ? 16'h0000 : 16'(p.operand_a << count);
            CMD_SHR:   r = (count >= 16) ? 16'h0000 : 16'(p.operand_a >> count);
            CMD_MERGE: r = 16'(p.operand_a << MERGE_SHIFT) | (p.operand_b & MERGE_LOW_MASK);
            default:   r = 16'h0000;
         endcase
         zero = (r == 16'h0000);
         neg  = r[15];
         case (p.condition)
            COND_EQ:    holds = zero;
            COND_NEQ:   holds = !zero;
            COND_SLT:   holds = neg;
            COND_SLTEQ: holds = zero || neg;
            COND_SGT:   holds = !neg && !zero;
            COND_SGTEQ: holds = !neg;
            COND_LT:    holds = old_carry && !zero;
            default:    holds = old_carry || zero;
         endcase
         if (p.load_flags) begin
            flags = r;
         end else if (p.update_carry) begin
            flags = (flags & CARRY_CLEAR_MASK) | (16'(carry_pending) << CARRY_BIT);
         end
         e.alu_result  = r;
         e.skip        = p.check_condition && holds;
         e.flags_value = flags;
         owed_q.push_back(e);
      endfunction

      task report(string msg);
         $display("[%0t] mismatch: %s", $time, msg);
         errors++;
      endtask

      task check_response(rsp_payload_type got);
         rsp_payload_type want;
         if (owed_q.size() == 0) begin
            report($sformatf("response %h with nothing owed", got));
            return;
         end
         want = owed_q.pop_front();
         if (got.alu_result !== want.alu_result)
            report($sformatf("alu_result %h, want %h", got.alu_result, want.alu_result));
         if (got.skip !== want.skip)
            report($sformatf("skip %b, want %b", got.skip, want.skip));
         if (got.flags_value !== want.flags_value)
            report($sformatf("flags_value %h, want %h", got.flags_value, want.flags_value));
      endtask
   endclass

   logic            clock;
   logic            reset;
   logic            calm;
   int              cycles;
   flags_scoreboard sb;

   alucs_stream_if #(.payload_type(req_payload_type)) req_if ();
   alucs_stream_if #(.payload_type(rsp_payload_type)) rsp_if ();

   alu_with_carry_and_skip_condition_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_stream (req_if),
      .rsp_stream (rsp_if)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic int pick_gap();
      int roll;
      if (calm) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 20);
   endfunction

   // Enter at a falling edge, leave at the falling edge after acceptance.
   task send_request(input req_payload_type p);
      int idle;
      idle = pick_gap();
      if (idle > 0) begin
         req_if.valid <= 1'b0;
         repeat (idle) @(negedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.payload <= p;
      do @(posedge clock); while (!req_if.ready);
      sb.note_request(p);
      @(negedge clock);
   endtask

   task send_fields(input logic [15:0] a, input logic [15:0] b, input logic [2:0] cmd,
                    input logic [2:0] cond, input logic chk, input logic upd, input logic ld);
      req_payload_type p;
      p.operand_a       = a;
      p.operand_b       = b;
      p.command         = cmd;
      p.condition       = cond;
      p.check_condition = chk;
      p.update_carry    = upd;
      p.load_flags      = ld;
      send_request(p);
   endtask

   function automatic logic [15:0] pick_operand();
      case ($urandom_range(0, 7))
         0:       return 16'h0000;
         1:       return 16'hffff;
         2:       return 16'h8000;
         3:       return 16'h7fff;
         default: return 16'($urandom());
      endcase
   endfunction

   function automatic req_payload_type pick_request();
      req_payload_type p;
      p.operand_a = pick_operand();
      p.operand_b = pick_operand();
      p.command   = 3'($urandom_range(0, 7));
      // keep shift counts mostly near the 16-bit boundary
      if ((p.command == CMD_SHL || p.command == CMD_SHR) && $urandom_range(0, 3) != 0)
         p.operand_b = 16'($urandom_range(0, 17));
      // equal operands give zero results for sub
      if (p.command == CMD_SUB && $urandom_range(0, 7) == 0)
         p.operand_b = p.operand_a;
      p.condition       = 3'($urandom_range(0, 7));
      p.check_condition = ($urandom_range(0, 3) != 0);
      p.update_carry    = 1'($urandom_range(0, 1));
      p.load_flags      = ($urandom_range(0, 7) == 0);
      return p;
   endfunction

   // Result side: random stalls, none while calm.
   initial begin
      int stall;
      stall        = 0;
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            stall--;
         end else begin
            rsp_if.ready <= 1'b1;
            stall = pick_gap();
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready)
         sb.check_response(rsp_if.payload);
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      sb             = new();
      calm           = 1'b0;
      reset          = 1'b1;
      req_if.valid   = 1'b0;
      req_if.payload = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // carry out of add, then unsigned conditions on the stored carry
      send_fields(16'hffff, 16'h0001, CMD_ADD,   COND_EQ,    1'b1, 1'b1, 1'b0);
      send_fields(16'hffff, 16'h1234, CMD_AND,   COND_LT,    1'b1, 1'b0, 1'b0);
      send_fields(16'h0000, 16'h0000, CMD_OR,    COND_LTEQ,  1'b1, 1'b0, 1'b0);
      send_fields(16'h0005, 16'h0005, CMD_SUB,   COND_NEQ,   1'b1, 1'b1, 1'b0);
      // borrow latched but not yet copied into the flags
      send_fields(16'h0000, 16'h0001, CMD_SUB,   COND_SLT,   1'b1, 1'b0, 1'b0);
      send_fields(16'h0001, 16'h0000, CMD_SHL,   COND_SLTEQ, 1'b1, 1'b1, 1'b0);
      send_fields(16'h0001, 16'd14,   CMD_SHL,   COND_SGT,   1'b1, 1'b0, 1'b0);
      send_fields(16'hffff, 16'd15,   CMD_SHL,   COND_SGTEQ, 1'b1, 1'b0, 1'b0);
      send_fields(16'hffff, 16'hffff, CMD_SHL,   COND_LT,    1'b1, 1'b0, 1'b0);
      send_fields(16'hffff, 16'h0000, CMD_SHR,   COND_SGT,   1'b1, 1'b0, 1'b0);
      send_fields(16'h8000, 16'd14,   CMD_SHR,   COND_LTEQ,  1'b1, 1'b0, 1'b0);
      send_fields(16'hffff, 16'd15,   CMD_SHR,   COND_EQ,    1'b1, 1'b0, 1'b0);
      send_fields(16'hffff, 16'hffff, CMD_SHR,   COND_NEQ,   1'b1, 1'b0, 1'b0);
      send_fields(16'hffff, 16'hffff, CMD_MERGE, COND_SLT,   1'b1, 1'b0, 1'b1);
      send_fields(16'h0000, 16'h0000, CMD_MERGE, COND_EQ,    1'b1, 1'b1, 1'b0);
      send_fields(16'hffff, 16'hffff, CMD_ZERO,  COND_EQ,    1'b0, 1'b0, 1'b0);
      // load wins over carry update
      send_fields(16'hffff, 16'hffff, CMD_ZERO,  COND_EQ,    1'b1, 1'b1, 1'b1);
      send_fields(16'h7fff, 16'h0001, CMD_ADD,   COND_SGTEQ, 1'b1, 1'b1, 1'b0);
      send_fields(16'h0000, 16'h0000, CMD_ADD,   COND_NEQ,   1'b1, 1'b0, 1'b0);
      send_fields(16'h8000, 16'h7fff, CMD_SUB,   COND_SGT,   1'b1, 1'b1, 1'b0);
      send_fields(16'haaaa, 16'h5555, CMD_OR,    COND_LTEQ,  1'b0, 1'b0, 1'b1);
      send_fields(16'h0000, 16'hffff, CMD_AND,   COND_LT,    1'b1, 1'b0, 1'b0);
      send_fields(16'h1234, 16'h5678, CMD_MERGE, COND_SLTEQ, 1'b1, 1'b1, 1'b0);

      for (int i = 0; i < RANDOM_REQUESTS; i++) begin
         // stretches with no gaps on either side
         calm = ((i % 400) >= 320);
         send_request(pick_request());
      end
      req_if.valid <= 1'b0;
      calm = 1'b0;

      while (sb.owed_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.owed_q.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
